// File: hdl/pwcr_pkg.sv
// ----------------------------------------------------------------------------
// pwcr_pkg
// Shared types and constants for the peak window change reporter.
// ----------------------------------------------------------------------------
`default_nettype none

package pwcr_pkg;

    localparam int SAMPLE_BITS_DEF = 16;
    localparam int TIME_W          = 62;
    localparam int LEN_W           = 16;
    localparam int RND_W           = 16;
    localparam int CFG_DATA_W      = 62;
    localparam int CFG_IDX_W       = 2;

    // register indexes on the configuration port
    localparam logic [CFG_IDX_W-1:0] CFG_SUBFRAME_LEN = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_ROUNDING     = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_DELAY    = 2'd2;

    // register reset values
    localparam logic [LEN_W-1:0]  SUBFRAME_LEN_RST = 16'd64;
    localparam logic [RND_W-1:0]  ROUNDING_RST     = 16'd1;
    localparam logic [TIME_W-1:0] MAX_DELAY_RST    = 62'd1000000000;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_START,
        ST_DIV,
        ST_EVAL,
        ST_SECOND
    } pwcr_state_t;

endpackage

`default_nettype wire

// File: hdl/pwcr_window.sv
// ----------------------------------------------------------------------------
// pwcr_window
// Window tracker: counts samples, keeps the first-largest-magnitude sample
// and the window start time, flags the sample that closes the window.
// ----------------------------------------------------------------------------
`default_nettype none

module pwcr_window #(
    parameter int SAMPLE_BITS = pwcr_pkg::SAMPLE_BITS_DEF
) (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           accept,
    input  wire logic signed [SAMPLE_BITS-1:0]  sample,
    input  wire logic [pwcr_pkg::TIME_W-1:0]    sample_time,
    input  wire logic                           frame_end,
    input  wire logic [pwcr_pkg::LEN_W-1:0]     subframe_len,
    output logic                                win_close,
    output logic [SAMPLE_BITS-1:0]              win_peak,
    output logic [pwcr_pkg::TIME_W-1:0]         win_time
);
    import pwcr_pkg::*;

    logic [LEN_W-1:0]       count_reg, count_next;
    logic [SAMPLE_BITS-1:0] peak_reg, peak_next;
    logic [TIME_W-1:0]      time_reg, time_next;
    logic [LEN_W:0]         cnt_inc;
    logic [LEN_W:0]         len_eff;
    logic [SAMPLE_BITS-1:0] s_u;
    logic [SAMPLE_BITS-1:0] s_mag;
    logic [SAMPLE_BITS-1:0] p_mag;

    always_comb
    begin
        s_u     = sample;
        s_mag   = s_u[SAMPLE_BITS-1] ? (~s_u + 1'b1) : s_u;
        p_mag   = peak_reg[SAMPLE_BITS-1] ? (~peak_reg + 1'b1) : peak_reg;
        // zero length means a full 65536-sample window
        len_eff = (subframe_len == '0) ? {1'b1, {LEN_W{1'b0}}} : {1'b0, subframe_len};
        cnt_inc = {1'b0, count_reg} + 1'b1;
        win_close = frame_end || (cnt_inc >= len_eff);

        count_next = count_reg;
        peak_next  = peak_reg;
        time_next  = time_reg;
        if (accept)
        begin
            if (count_reg == '0)
            begin
                peak_next = s_u;
                time_next = sample_time;
            end
            else if (s_mag > p_mag)
            begin
                peak_next = s_u;
            end
            count_next = win_close ? '0 : cnt_inc[LEN_W-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
        end
        else
        begin
            count_reg <= count_next;
        end
    end

    // written on the first sample of each window before any read
    always_ff @(posedge clk)
    begin
        peak_reg <= peak_next;
        time_reg <= time_next;
    end

    assign win_peak = peak_reg;
    assign win_time = time_reg;

endmodule

`default_nettype wire

// File: hdl/pwcr_divider.sv
// ----------------------------------------------------------------------------
// pwcr_divider
// Restoring remainder unit, one dividend bit per cycle through a single
// 17-bit subtractor.
// ----------------------------------------------------------------------------
`default_nettype none

module pwcr_divider #(
    parameter int DIVIDEND_W = pwcr_pkg::SAMPLE_BITS_DEF
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          start,
    input  wire logic [DIVIDEND_W-1:0]         dividend,
    input  wire logic [pwcr_pkg::RND_W-1:0]    divisor,
    output logic [pwcr_pkg::RND_W-1:0]         remainder,
    output logic                               done
);
    import pwcr_pkg::*;

    localparam int CW = $clog2(DIVIDEND_W + 1);

    logic [CW-1:0]         cnt_reg, cnt_next;
    logic                  done_reg, done_next;
    logic [DIVIDEND_W-1:0] sh_reg, sh_next;
    logic [RND_W-1:0]      rem_reg, rem_next;
    logic [RND_W:0]        trial;

    always_comb
    begin
        trial     = {rem_reg, sh_reg[DIVIDEND_W-1]} - {1'b0, divisor};
        cnt_next  = cnt_reg;
        sh_next   = sh_reg;
        rem_next  = rem_reg;
        done_next = 1'b0;
        if (start)
        begin
            cnt_next = CW'(DIVIDEND_W);
            sh_next  = dividend;
            rem_next = '0;
        end
        else if (cnt_reg != '0)
        begin
            sh_next   = {sh_reg[DIVIDEND_W-2:0], 1'b0};
            rem_next  = trial[RND_W] ? {rem_reg[RND_W-2:0], sh_reg[DIVIDEND_W-1]}
                                     : trial[RND_W-1:0];
            cnt_next  = cnt_reg - 1'b1;
            done_next = (cnt_reg == CW'(1));
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            done_reg <= 1'b0;
        end
        else
        begin
            cnt_reg  <= cnt_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        sh_reg  <= sh_next;
        rem_reg <= rem_next;
    end

    assign remainder = rem_reg;
    assign done      = done_reg;

endmodule

`default_nettype wire

// File: hdl/peak_window_change_reporter.sv
// ----------------------------------------------------------------------------
// peak_window_change_reporter
// Per-window peak detector with quantization and change/timeout reporting.
// ----------------------------------------------------------------------------
// A sample that leaves its window open keeps in_ready high, so such samples are taken back to back.
// A window-closing sample holds in_ready low through ST_START, then ST_DIV until
//   the remainder unit's registered done, then ST_EVAL; a second word adds
//   ST_SECOND, and a stalled report channel holds ST_EVAL or ST_SECOND longer.
// Reset (rst_n, async, active low): registers take their reset values,
//   window, held and reported state clear, no word is pending.
// ----------------------------------------------------------------------------
`default_nettype none

module peak_window_change_reporter #(
    parameter int SAMPLE_BITS = pwcr_pkg::SAMPLE_BITS_DEF
) (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    // configuration write port
    input  wire logic                              cfg_wr_en,
    input  wire logic [pwcr_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  wire logic [pwcr_pkg::CFG_DATA_W-1:0]   cfg_data,
    // sample channel
    input  wire logic                              in_valid,
    output logic                                   in_ready,
    input  wire logic signed [SAMPLE_BITS-1:0]     sample,
    input  wire logic [pwcr_pkg::TIME_W-1:0]       sample_time,
    input  wire logic                              frame_end,
    input  wire logic                              direction_out,
    // report channel
    output logic                                   out_valid,
    input  wire logic                              out_ready,
    output logic [pwcr_pkg::TIME_W-1:0]            report_time,
    output logic signed [SAMPLE_BITS-1:0]          report_value,
    output logic                                   report_direction_out,
    output logic                                   last_of_run
);
    import pwcr_pkg::*;

    // common width for the quotient-times-step subtraction
    localparam int WW = (SAMPLE_BITS > RND_W) ? SAMPLE_BITS : RND_W;

    // configuration registers
    logic [LEN_W-1:0]  subframe_len_reg;
    logic [RND_W-1:0]  rounding_reg;
    logic [TIME_W-1:0] max_delay_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            subframe_len_reg <= SUBFRAME_LEN_RST;
            rounding_reg     <= ROUNDING_RST;
            max_delay_reg    <= MAX_DELAY_RST;
        end
        else if (cfg_wr_en)
        begin
            unique case (cfg_index)
                CFG_SUBFRAME_LEN: subframe_len_reg <= cfg_data[LEN_W-1:0];
                CFG_ROUNDING:     rounding_reg     <= cfg_data[RND_W-1:0];
                CFG_MAX_DELAY:    max_delay_reg    <= cfg_data[TIME_W-1:0];
                default:          ; // unmapped index, ignored
            endcase
        end
    end

    pwcr_state_t state_reg, state_next;

    logic in_fire;
    logic out_fire;
    logic slot_free;
    logic win_close;
    logic [SAMPLE_BITS-1:0] win_peak;
    logic [TIME_W-1:0]      win_time;

    assign in_ready  = (state_reg == ST_IDLE);
    assign in_fire   = in_valid && in_ready;
    assign out_fire  = out_valid && out_ready;
    // output register empty now or emptied at this edge
    assign slot_free = !out_valid || out_ready;

    pwcr_window #(
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_window (
        .clk          (clk),
        .rst_n        (rst_n),
        .accept       (in_fire),
        .sample       (sample),
        .sample_time  (sample_time),
        .frame_end    (frame_end),
        .subframe_len (subframe_len_reg),
        .win_close    (win_close),
        .win_peak     (win_peak),
        .win_time     (win_time)
    );

    // |peak| as unsigned; the most negative value maps to 2^(SAMPLE_BITS-1)
    logic                   peak_neg;
    logic [SAMPLE_BITS-1:0] peak_mag;
    logic [RND_W-1:0]       step_eff;
    logic [RND_W-1:0]       div_rem;
    logic                   div_done;

    assign peak_neg = win_peak[SAMPLE_BITS-1];
    assign peak_mag = peak_neg ? (~win_peak + 1'b1) : win_peak;
    // zero step behaves as one
    assign step_eff = (rounding_reg == '0) ? RND_W'(1) : rounding_reg;

    pwcr_divider #(
        .DIVIDEND_W (SAMPLE_BITS)
    ) u_divider (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (state_reg == ST_START),
        .dividend  (peak_mag),
        .divisor   (step_eff),
        .remainder (div_rem),
        .done      (div_done)
    );

    // held and reported window state
    logic [TIME_W-1:0]      held_time_reg, held_time_next;
    logic [SAMPLE_BITS-1:0] held_value_reg, held_value_next;
    logic [TIME_W-1:0]      reported_time_reg, reported_time_next;
    logic                   dir_reg, dir_next;

    // output register
    logic                   out_valid_reg, out_valid_next;
    logic [TIME_W-1:0]      out_time_reg, out_time_next;
    logic [SAMPLE_BITS-1:0] out_value_reg, out_value_next;
    logic                   out_dir_reg, out_dir_next;
    logic                   out_last_reg, out_last_next;

    // evaluation terms
    logic [WW-1:0]          q_w;
    logic [SAMPLE_BITS-1:0] q_s;
    logic [SAMPLE_BITS-1:0] nv;
    logic                   changed;
    logic signed [TIME_W:0] gap;
    logic                   overdue;
    logic                   emit_held;
    logic                   emit_new;
    logic [TIME_W-1:0]      rep_mid;

    always_comb
    begin
        // truncate toward zero: mag - (mag mod step)
        q_w     = WW'(peak_mag) - WW'(div_rem);
        q_s     = q_w[SAMPLE_BITS-1:0];
        nv      = peak_neg ? (~q_s + 1'b1) : q_s;
        changed = (nv != held_value_reg);
        // signed gap: a window earlier than the last report never times out
        gap     = $signed({1'b0, win_time}) - $signed({1'b0, reported_time_reg});
        overdue = gap > $signed({1'b0, max_delay_reg});

        emit_held = (changed || overdue) && (held_time_reg != '0)
                    && (reported_time_reg != held_time_reg);
        rep_mid   = emit_held ? held_time_reg : reported_time_reg;
        emit_new  = changed && (win_time != '0) && (rep_mid != win_time);
    end

    always_comb
    begin
        state_next         = state_reg;
        held_time_next     = held_time_reg;
        held_value_next    = held_value_reg;
        reported_time_next = reported_time_reg;
        dir_next           = dir_reg;
        out_valid_next     = out_valid_reg && !out_fire;
        out_time_next      = out_time_reg;
        out_value_next     = out_value_reg;
        out_dir_next       = out_dir_reg;
        out_last_next      = out_last_reg;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_fire)
                begin
                    dir_next = direction_out;
                    if (win_close)
                    begin
                        state_next = ST_START;
                    end
                end
            end
            ST_START:
            begin
                state_next = ST_DIV;
            end
            ST_DIV:
            begin
                if (div_done)
                begin
                    state_next = ST_EVAL;
                end
            end
            ST_EVAL:
            begin
                // commit only once the output slot can take a word
                if (slot_free)
                begin
                    held_time_next  = win_time;
                    held_value_next = nv;
                    if (emit_new)
                    begin
                        reported_time_next = win_time;
                    end
                    else if (emit_held)
                    begin
                        reported_time_next = held_time_reg;
                    end

                    if (emit_held)
                    begin
                        out_valid_next = 1'b1;
                        out_time_next  = held_time_reg;
                        out_value_next = held_value_reg;
                        out_dir_next   = dir_reg;
                        out_last_next  = !emit_new;
                    end
                    else if (emit_new)
                    begin
                        out_valid_next = 1'b1;
                        out_time_next  = win_time;
                        out_value_next = nv;
                        out_dir_next   = dir_reg;
                        out_last_next  = 1'b1;
                    end

                    state_next = (emit_held && emit_new) ? ST_SECOND : ST_IDLE;
                end
            end
            ST_SECOND:
            begin
                // new window is already in the held registers
                if (slot_free)
                begin
                    out_valid_next = 1'b1;
                    out_time_next  = held_time_reg;
                    out_value_next = held_value_reg;
                    out_dir_next   = dir_reg;
                    out_last_next  = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg         <= ST_IDLE;
            held_time_reg     <= '0;
            held_value_reg    <= '0;
            reported_time_reg <= '0;
            out_valid_reg     <= 1'b0;
        end
        else
        begin
            state_reg         <= state_next;
            held_time_reg     <= held_time_next;
            held_value_reg    <= held_value_next;
            reported_time_reg <= reported_time_next;
            out_valid_reg     <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        dir_reg       <= dir_next;
        out_time_reg  <= out_time_next;
        out_value_reg <= out_value_next;
        out_dir_reg   <= out_dir_next;
        out_last_reg  <= out_last_next;
    end

    assign out_valid            = out_valid_reg;
    assign report_time          = out_time_reg;
    assign report_value         = out_value_reg;
    assign report_direction_out = out_dir_reg;
    assign last_of_run          = out_last_reg;

endmodule

`default_nettype wire

// File: hdl/pwcr_checker.sv
// ----------------------------------------------------------------------------
// pwcr_checker
// Port-level checks for the peak window change reporter, bound to the top.
// ----------------------------------------------------------------------------
`default_nettype none

module pwcr_checker #(
    parameter int SAMPLE_BITS = pwcr_pkg::SAMPLE_BITS_DEF
) (
    input wire logic                              clk,
    input wire logic                              rst_n,
    input wire logic                              in_ready,
    input wire logic                              out_valid,
    input wire logic                              out_ready,
    input wire logic [pwcr_pkg::TIME_W-1:0]       report_time,
    input wire logic signed [SAMPLE_BITS-1:0]     report_value,
    input wire logic                              report_direction_out,
    input wire logic                              last_of_run
);
    import pwcr_pkg::*;

    // stalled word holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(report_time)
            && $stable(report_value) && $stable(report_direction_out)
            && $stable(last_of_run))
        else $error("report word changed while stalled");

    // a window with time zero is never reported
    a_time_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> report_time != '0)
        else $error("report with zero time");

    // the second word of a pair follows right after the first is taken
    a_pair_follows: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_ready && !last_of_run |=> out_valid && last_of_run)
        else $error("second report word missing");

    // no new sample while the first word of a pair waits
    a_pair_blocks: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !last_of_run |-> !in_ready)
        else $error("sample taken while pair pending");

endmodule

bind peak_window_change_reporter pwcr_checker #(
    .SAMPLE_BITS (SAMPLE_BITS)
) u_pwcr_checker (.*);

`default_nettype wire
